>>> hdl/chained_hash_table_core_macros.svh
// assertion macros for the chained hash table core
// no dependencies; define ASSERT_OFF to drop all checks
`ifndef CHAINED_HASH_TABLE_CORE_MACROS_SVH
`define CHAINED_HASH_TABLE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define CHT_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CHT_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHT_ASSERT(label, clk, rstn, prop, msg)
`define CHT_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

>>> hdl/cht_pkg.sv
// shared types and codes for the chained hash table core
// no dependencies
package cht_pkg;
    localparam logic [1:0] REQ_FIND   = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_HEAD,
        S_HEADW,
        S_NODE,
        S_NODEW,
        S_ACT,
        S_POPW,
        S_LINK,
        S_RM1,
        S_DONE
    } state_t;
endpackage

>>> hdl/chained_hash_table_core.sv
// chained hash table core: top level with control sequencer
// depends on cht_pkg, cht_ram and chained_hash_table_core_macros.svh
`include "chained_hash_table_core_macros.svh"

// Hash map with separate chaining over a pool of NODES nodes. Each request
// carries a precomputed 32-bit key hash; equal hashes are equal keys. The
// hash modulo BUCKETS picks a chain; find walks it, insert updates a match
// or pushes a node taken from the free stack at the chain head, remove
// unlinks the node and pushes it back on the free stack. One result per
// request. Requests are handled one at a time. Each request is accepted,
// the bucket head is read, each chain node visited is read (the node
// memories have registered read data), then the update is made and the
// result posted (an insert of a new key pops the free stack and fixes the
// old head's back link; a remove fixes both neighbours), and the result is
// handed over. After reset a clearing pass empties the bucket heads and
// fills the free stack; no request is taken meanwhile. The result sits in
// an output register, so s_ready rises again as soon as it is handed over.
module chained_hash_table_core
    import cht_pkg::*;
#(
    parameter int BUCKETS = 128,
    parameter int NODES   = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_key_hash,
    input  logic [31:0] s_value_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [31:0] m_value_out
);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int PW = NW + 1;                 // node pointer, NODES is null
    localparam int CW = $clog2(NODES + 1);      // free count
    localparam int IW = (BW > NW) ? BW : NW;    // clearing sweep index
    localparam int SWEEP = (BUCKETS > NODES) ? BUCKETS : NODES;
    localparam logic [PW-1:0] NIL = PW'(NODES);
    localparam logic [CW-1:0] FULL_CNT = CW'(NODES);

    state_t state_reg, state_next;

    // captured request
    logic [1:0]  type_reg, type_next;
    logic [31:0] hash_reg, hash_next;
    logic [31:0] val_reg, val_next;
    logic [BW-1:0] bkt_reg, bkt_next;
    // walk state
    logic [PW-1:0] cur_reg, cur_next;
    logic [PW-1:0] old_reg, old_next;
    logic [PW-1:0] prv_reg, prv_next;
    logic [PW-1:0] nxt_reg, nxt_next;
    logic [CW-1:0] fcnt_reg, fcnt_next;
    logic [IW:0]   swp_reg, swp_next;
    // result register
    logic        mv_reg, mv_next;
    logic [1:0]  ms_reg, ms_next;
    logic [31:0] mo_reg, mo_next;

    // memory ports
    logic          bh_we;   logic [BW-1:0] bh_wa, bh_ra; logic [PW-1:0] bh_wd, bh_rd;
    logic          eh_we;   logic [NW-1:0] e_wa, e_ra;   logic [31:0] eh_wd, eh_rd;
    logic          ev_we;   logic [31:0] ev_wd, ev_rd;
    logic          en_we;   logic [NW-1:0] en_wa;        logic [PW-1:0] en_wd, en_rd;
    logic          ep_we;   logic [NW-1:0] ep_wa;        logic [PW-1:0] ep_wd, ep_rd;
    logic          fs_we;   logic [NW-1:0] fs_wa, fs_ra; logic [NW-1:0] fs_wd, fs_rd;

    cht_ram #(.WIDTH(PW), .DEPTH(BUCKETS)) u_head (
        .aclk(aclk), .we(bh_we), .waddr(bh_wa), .wdata(bh_wd), .raddr(bh_ra), .rdata(bh_rd));
    cht_ram #(.WIDTH(32), .DEPTH(NODES)) u_hash (
        .aclk(aclk), .we(eh_we), .waddr(e_wa), .wdata(eh_wd), .raddr(e_ra), .rdata(eh_rd));
    cht_ram #(.WIDTH(32), .DEPTH(NODES)) u_value (
        .aclk(aclk), .we(ev_we), .waddr(e_wa), .wdata(ev_wd), .raddr(e_ra), .rdata(ev_rd));
    cht_ram #(.WIDTH(PW), .DEPTH(NODES)) u_next (
        .aclk(aclk), .we(en_we), .waddr(en_wa), .wdata(en_wd), .raddr(e_ra), .rdata(en_rd));
    cht_ram #(.WIDTH(PW), .DEPTH(NODES)) u_prev (
        .aclk(aclk), .we(ep_we), .waddr(ep_wa), .wdata(ep_wd), .raddr(e_ra), .rdata(ep_rd));
    cht_ram #(.WIDTH(NW), .DEPTH(NODES)) u_free (
        .aclk(aclk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd), .raddr(fs_ra), .rdata(fs_rd));

    // bucket index: hash mod BUCKETS (a mask for power-of-two bucket counts)
    logic [BW-1:0] s_bkt;
    assign s_bkt = BW'(s_key_hash % BUCKETS);

    assign s_ready     = (state_reg == S_IDLE) && !mv_reg;
    assign m_valid     = mv_reg;
    assign m_status    = ms_reg;
    assign m_value_out = mo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            swp_reg   <= '0;
            fcnt_reg  <= FULL_CNT;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            swp_reg   <= swp_next;
            fcnt_reg  <= fcnt_next;
            mv_reg    <= mv_next;
        end
        type_reg <= type_next;
        hash_reg <= hash_next;
        val_reg  <= val_next;
        bkt_reg  <= bkt_next;
        cur_reg  <= cur_next;
        old_reg  <= old_next;
        prv_reg  <= prv_next;
        nxt_reg  <= nxt_next;
        ms_reg   <= ms_next;
        mo_reg   <= mo_next;
    end

    always_comb begin
        state_next = state_reg;
        type_next = type_reg; hash_next = hash_reg; val_next = val_reg;
        bkt_next = bkt_reg; cur_next = cur_reg; old_next = old_reg;
        prv_next = prv_reg; nxt_next = nxt_reg; fcnt_next = fcnt_reg;
        swp_next = swp_reg;
        mv_next = mv_reg; ms_next = ms_reg; mo_next = mo_reg;

        bh_we = 1'b0; bh_wa = bkt_reg; bh_wd = NIL; bh_ra = bkt_reg;
        eh_we = 1'b0; ev_we = 1'b0; en_we = 1'b0; ep_we = 1'b0; fs_we = 1'b0;
        e_wa = cur_reg[NW-1:0]; e_ra = cur_reg[NW-1:0];
        eh_wd = hash_reg; ev_wd = val_reg;
        en_wa = cur_reg[NW-1:0]; en_wd = old_reg;
        ep_wa = cur_reg[NW-1:0]; ep_wd = NIL;
        fs_wa = fcnt_reg[NW-1:0]; fs_wd = cur_reg[NW-1:0];
        fs_ra = NW'(fcnt_reg - CW'(1));

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_INIT: begin
                // clearing pass: empty heads, free stack holds every node
                if (swp_reg < (IW+1)'(BUCKETS)) begin
                    bh_we = 1'b1;
                    bh_wa = swp_reg[BW-1:0];
                end
                if (swp_reg < (IW+1)'(NODES)) begin
                    fs_we = 1'b1;
                    fs_wa = swp_reg[NW-1:0];
                    fs_wd = swp_reg[NW-1:0];
                end
                swp_next = swp_reg + 1'b1;
                if (swp_reg == (IW+1)'(SWEEP - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                bh_ra = s_bkt;
                if (s_valid && s_ready) begin
                    type_next = s_req_type;
                    hash_next = s_key_hash;
                    val_next = s_value_in;
                    bkt_next = s_bkt;
                    state_next = S_HEAD;
                end
            end
            S_HEAD: begin
                state_next = S_HEADW;
            end
            S_HEADW: begin
                // head pointer read data valid
                old_next = bh_rd;
                cur_next = bh_rd;
                if (bh_rd >= NIL) begin
                    state_next = S_ACT;
                end else begin
                    e_ra = bh_rd[NW-1:0];
                    state_next = S_NODE;
                end
            end
            S_NODE: begin
                e_ra = cur_reg[NW-1:0];
                state_next = S_NODEW;
            end
            S_NODEW: begin
                if (eh_rd == hash_reg) begin
                    prv_next = ep_rd;
                    nxt_next = en_rd;
                    mo_next = ev_rd;
                    state_next = S_ACT;
                end else begin
                    cur_next = en_rd;
                    if (en_rd >= NIL) begin
                        state_next = S_ACT;
                    end else begin
                        state_next = S_NODE;
                    end
                end
            end
            S_ACT: begin
                // cur_reg is the matching node or null
                ms_next = ST_NOTFOUND;
                mo_next = (type_reg == REQ_FIND && cur_reg < NIL) ? mo_reg : 32'd0;
                state_next = S_DONE;
                case (type_reg)
                    REQ_FIND: begin
                        if (cur_reg < NIL) ms_next = ST_OK;
                    end
                    REQ_INSERT: begin
                        if (cur_reg < NIL) begin
                            ev_we = 1'b1;
                            ms_next = ST_OK;
                        end else if (fcnt_reg == '0) begin
                            ms_next = ST_FULL;
                        end else begin
                            fs_ra = NW'(fcnt_reg - CW'(1));
                            fcnt_next = fcnt_reg - CW'(1);
                            ms_next = ST_OK;
                            state_next = S_POPW;
                        end
                    end
                    REQ_REMOVE: begin
                        if (cur_reg < NIL) begin
                            ms_next = ST_OK;
                            if (prv_reg < NIL) begin
                                en_we = 1'b1;
                                en_wa = prv_reg[NW-1:0];
                                en_wd = nxt_reg;
                            end else begin
                                bh_we = 1'b1;
                                bh_wd = nxt_reg;
                            end
                            fs_we = 1'b1;
                            fcnt_next = fcnt_reg + CW'(1);
                            state_next = S_RM1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_POPW: begin
                // popped node index ready: write node and head
                cur_next = {1'b0, fs_rd};
                e_wa = fs_rd; en_wa = fs_rd; ep_wa = fs_rd;
                eh_we = 1'b1; ev_we = 1'b1; en_we = 1'b1; ep_we = 1'b1;
                bh_we = 1'b1; bh_wd = {1'b0, fs_rd};
                state_next = (old_reg < NIL) ? S_LINK : S_DONE;
            end
            S_LINK: begin
                ep_we = 1'b1;
                ep_wa = old_reg[NW-1:0];
                ep_wd = cur_reg;
                state_next = S_DONE;
            end
            S_RM1: begin
                if (nxt_reg < NIL) begin
                    ep_we = 1'b1;
                    ep_wa = nxt_reg[NW-1:0];
                    ep_wd = prv_reg;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                mv_next = 1'b1;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `CHT_ASSERT(a_count_range, aclk, aresetn, fcnt_reg <= FULL_CNT, "free count above pool size")
    `CHT_ASSERT(a_one_request, aclk, aresetn, s_ready |-> !mv_reg, "request taken with result pending")
    `CHT_ASSERT(a_full_no_pop, aclk, aresetn, (state_reg == S_POPW) |-> ($past(fcnt_reg) != '0), "pop from empty free stack")
    `CHT_ASSERT(a_done_result, aclk, aresetn, (state_reg == S_DONE) |=> mv_reg, "result lost")
endmodule

>>> hdl/cht_ram.sv
// generic single-port-write, single-read ram with registered read data
// no dependencies
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sim/chained_hash_table_checker.sv
// request/result checker for the chained hash table core
// depends on cht_pkg; keeps its own copy of the table and compares every result
`timescale 1ns / 100ps

module chained_hash_table_checker
    import cht_pkg::*;
#(
    parameter int BUCKETS = 128,
    parameter int NODES   = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_key_hash,
    input  logic [31:0] s_value_in,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [31:0] m_value_out,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
    } answer_t;

    localparam int NIL = NODES;

    int          head_of[BUCKETS];
    logic [31:0] node_key[NODES];
    logic [31:0] node_val[NODES];
    int          node_nxt[NODES];
    int          node_prv[NODES];
    int          spare[NODES];
    int          spare_cnt;
    answer_t     answers_due[$];

    function automatic int lookup(logic [31:0] h);
        int n;
        int steps;
        n = head_of[h % BUCKETS];
        steps = 0;
        while (n != NIL && steps < NODES) begin
            if (node_key[n] == h) return n;
            n = node_nxt[n];
            steps++;
        end
        return NIL;
    endfunction

    function automatic answer_t apply_request(logic [1:0] op, logic [31:0] h, logic [31:0] v);
        answer_t a;
        int n;
        int b;
        int p;
        int q;
        a.status = ST_NOTFOUND;
        a.value = '0;
        n = lookup(h);
        b = h % BUCKETS;
        case (op)
            REQ_FIND: begin
                if (n != NIL) begin
                    a.status = ST_OK;
                    a.value = node_val[n];
                end
            end
            REQ_INSERT: begin
                if (n != NIL) begin
                    node_val[n] = v;
                    a.status = ST_OK;
                end else if (spare_cnt == 0) begin
                    a.status = ST_FULL;
                end else begin
                    spare_cnt--;
                    n = spare[spare_cnt];
                    node_key[n] = h;
                    node_val[n] = v;
                    node_nxt[n] = head_of[b];
                    node_prv[n] = NIL;
                    if (head_of[b] != NIL) node_prv[head_of[b]] = n;
                    head_of[b] = n;
                    a.status = ST_OK;
                end
            end
            REQ_REMOVE: begin
                if (n != NIL) begin
                    p = node_prv[n];
                    q = node_nxt[n];
                    if (p != NIL) node_nxt[p] = q;
                    else head_of[b] = q;
                    if (q != NIL) node_prv[q] = p;
                    spare[spare_cnt] = n;
                    spare_cnt++;
                    a.status = ST_OK;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            // empty table, every node spare
            for (int i = 0; i < BUCKETS; i++) head_of[i] = NIL;
            for (int i = 0; i < NODES; i++) spare[i] = i;
            spare_cnt = NODES;
            fail_count = 0;
            answers_due.delete();
            pending = 0;
        end else begin
            if (s_valid && s_ready)
                answers_due.push_back(apply_request(s_req_type, s_key_hash, s_value_in));
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result status=%0d value=%h", m_status, m_value_out);
                end else begin
                    want = answers_due.pop_front();
                    if (want.status !== m_status || want.value !== m_value_out) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected status=%0d value=%h, got status=%0d value=%h",
                                     want.status, want.value, m_status, m_value_out);
                    end
                end
            end
            pending = answers_due.size();
        end
    end
endmodule

>>> sim/chained_hash_table_core_tb.sv
// testbench top for the chained hash table core
// depends on cht_pkg, chained_hash_table_core and chained_hash_table_checker
`timescale 1ns / 100ps

module chained_hash_table_core_tb;
    import cht_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = REQ_FIND;
    logic [31:0] s_key_hash = '0;
    logic [31:0] s_value_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [31:0] m_value_out;
    int          fail_count;
    int          pending;
    logic        stim_done = 1'b0;

    // idle percentages for the sender and the receiver, changed per phase
    int          send_idle_pct = 23;
    int          take_idle_pct = 62;
    logic [31:0] key_pool[$];

    always #6 aclk = ~aclk;

    chained_hash_table_core dut (.*);

    chained_hash_table_checker checker_i (.*);

    // receiver: random ready at each falling edge
    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= take_idle_pct);

    // present one request and hold it until the handshake
    task automatic send_request(logic [1:0] op, logic [31:0] h, logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= op;
        s_key_hash <= h;
        s_value_in <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // keys mostly from a small pool so chains get long and hits are common
    function automatic logic [31:0] pick_key();
        logic [31:0] k;
        if (key_pool.size() > 0 && $urandom_range(99) < 75)
            return key_pool[$urandom_range(key_pool.size() - 1)];
        // few low bits: many keys share a bucket
        k = $urandom();
        if ($urandom_range(1)) k[6:0] = 7'($urandom_range(3));
        key_pool.push_back(k);
        return k;
    endfunction

    task automatic random_phase(int count);
        int r;
        logic [1:0] op;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            op = (r < 40) ? REQ_INSERT : (r < 70) ? REQ_FIND : (r < 97) ? REQ_REMOVE : REQ_UNUSED;
            send_request(op, pick_key(), $urandom());
        end
    endtask

    initial begin
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: extremes, every op, absent keys, update, unused type
        send_request(REQ_FIND, 32'h0, 32'h0);
        send_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_request(REQ_INSERT, 32'h0, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h0);
        send_request(REQ_INSERT, 32'h0000_0080, 32'h1234_5678);  // same bucket as 0
        send_request(REQ_INSERT, 32'h0, 32'hA5A5_5A5A);          // update
        send_request(REQ_FIND, 32'h0, 32'h0);
        send_request(REQ_FIND, 32'h0000_0080, 32'h0);
        send_request(REQ_FIND, 32'h0000_0100, 32'h0);            // absent, busy chain
        send_request(REQ_UNUSED, 32'h0, 32'hFFFF_FFFF);
        send_request(REQ_REMOVE, 32'h0000_0080, 32'h0);          // head of chain
        send_request(REQ_REMOVE, 32'h0, 32'h0);                  // last one
        send_request(REQ_FIND, 32'h0, 32'h0);
        send_request(REQ_FIND, 32'hFFFF_FFFF, 32'h0);
        send_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'h0);

        // fill the pool to exhaustion, then refuse, then drain
        for (int i = 0; i < 258; i++)
            send_request(REQ_INSERT, {8'(i * 7), 24'(i)}, $urandom());
        for (int i = 0; i < 256; i++)
            send_request(REQ_REMOVE, {8'(i * 7), 24'(i)}, 32'h0);

        // hold off until every result is back
        s_valid <= 1'b0;
        wait (pending == 0);
        @(negedge aclk);

        random_phase(75);
        send_idle_pct = 62;
        take_idle_pct = 23;
        random_phase(75);
        send_idle_pct = 0;
        take_idle_pct = 0;
        random_phase(75);
        s_valid <= 1'b0;
        stim_done <= 1'b1;
    end

    // end of stimulus detection and verdict
    initial begin
        wait (stim_done);
        wait (pending == 0);
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
